// ===== hdl/udiv_pkg.sv =====
// udiv_pkg: shared types and constants for the unsigned divider
// used by udiv_ctrl, udiv_dpath and unsigned_divider_32
`timescale 1ns / 1ps
`default_nettype none

package udiv_pkg;

  // default operand width
  localparam int DIV_WIDTH = 32;

  // opcode values
  localparam logic OP_QUOTIENT  = 1'b0;
  localparam logic OP_REMAINDER = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/udiv_ctrl.sv =====
// udiv_ctrl: sequencing state machine of the unsigned divider
// depends on udiv_pkg (state_t, cmd_t, status_t)
`timescale 1ns / 1ps
`default_nettype none

module udiv_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  udiv_pkg::status_t status,
  output udiv_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import udiv_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    busy       = 1'b0;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // result shown for one cycle, next item may be taken meanwhile
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/udiv_dpath.sv =====
// udiv_dpath: operand registers, shift-subtract unit and step counter
// depends on udiv_pkg (cmd_t, status_t, opcode constants)
`timescale 1ns / 1ps
`default_nettype none

module udiv_dpath #(
  parameter int DATA_WIDTH = udiv_pkg::DIV_WIDTH
) (
  input  wire                    clk,
  input  udiv_pkg::cmd_t         cmd,
  input  wire                    opcode,
  input  wire [DATA_WIDTH-1:0]   dividend,
  input  wire [DATA_WIDTH-1:0]   divisor,
  output udiv_pkg::status_t      status,
  output logic [DATA_WIDTH-1:0]  value,
  output logic                   divide_by_zero
);
  import udiv_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dvsr;
  logic                  op;
  logic                  dz;
  logic [CW-1:0]         cnt;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;

  // one restoring step: shift in next dividend bit, try the subtract
  always_comb begin
    shifted = {rem, quo[DATA_WIDTH-1]};
    trial   = shifted - {1'b0, dvsr};
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
      op   <= opcode;
      dz   <= (divisor == '0);
      cnt  <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (!trial[DATA_WIDTH]) begin
        rem <= trial[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign status.last = (cnt == CW'(DATA_WIDTH - 1));

  // zero divisor falls out of the steps: all ones quotient, dividend remainder
  assign value          = (op == OP_REMAINDER) ? rem : quo;
  assign divide_by_zero = dz;

endmodule

`default_nettype wire

// ===== hdl/unsigned_divider_32.sv =====
// unsigned_divider_32: top level of the restoring unsigned divider
// depends on udiv_pkg, udiv_ctrl and udiv_dpath
`timescale 1ns / 1ps
`default_nettype none

// Usage
// An item (opcode, dividend, divisor) is taken at a rising edge where start
// is high and busy is low. opcode 0 returns the quotient, 1 the remainder.
// The divider then runs DATA_WIDTH shift-subtract steps (32 by default),
// one step per cycle, one quotient bit per step from the top bit down.
// The result (value, divide_by_zero) is then on the ports for exactly one
// cycle with done high; the receiver cannot stall and must take it there.
// done rises in ST_DONE, once the last step has been registered. During
// the done cycle busy is low, so a new item can be taken there; while an
// item is stepping (busy high) no new item is taken, since every step of
// it uses the single subtract unit.
// A zero divisor sets divide_by_zero; value is all ones for the quotient
// and the dividend for the remainder.
// Reset returns the controller to idle; any item in flight is dropped and
// no done pulse follows.
module unsigned_divider_32 #(
  parameter int DATA_WIDTH = udiv_pkg::DIV_WIDTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire                   opcode,
  input  wire [DATA_WIDTH-1:0]  dividend,
  input  wire [DATA_WIDTH-1:0]  divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] value,
  output logic                  divide_by_zero
);
  import udiv_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  udiv_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // arithmetic
  udiv_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .opcode         (opcode),
    .dividend       (dividend),
    .divisor        (divisor),
    .status         (status),
    .value          (value),
    .divide_by_zero (divide_by_zero)
  );

`ifndef ASSERT_OFF
  // an accepted item always leads into the step phase
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not start stepping");

  // done pulse comes only at the end of the step phase
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("done without preceding steps");

  // result strobe lasts a single cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // the step phase never shows a result
  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("done while stepping");
`endif

endmodule

`default_nettype wire
